// ===== src/ssr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the substring replace block
// Widths, register indexes, the command word that moves from the front end
// to the emitter, and the configuration event bundle.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int PAT_CAP         = 16;
  localparam int BYTE_W          = 8;
  localparam int CNT_W           = $clog2(PAT_CAP + 1);
  localparam int TOT_W           = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int DEF_MAX_FIND    = 16;
  localparam int DEF_MAX_REPL    = 16;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FIND_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIND_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIND_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_LO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_HI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_LEN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET   = 3'd6;

  localparam logic [TOT_W-1:0] RESET_BUDGET = 16'hFFFF;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Usable pattern bytes for a given storage limit.
  function automatic int cap_len(input int n);
    return (n < PAT_CAP) ? n : PAT_CAP;
  endfunction

  // One burst of output words: cnt data bytes from data (byte 0 first),
  // then an end report when fin is set. base is the byte count before it.
  typedef struct packed {
    logic [PAT_CAP*BYTE_W-1:0] data;
    logic [CNT_W-1:0]          cnt;
    logic                      fin;
    logic [TOT_W-1:0]          base;
  } cmd_t;

  typedef struct packed {
    logic             clear_fill;
    logic             set_budget;
    logic [TOT_W-1:0] budget;
  } cfg_ev_t;

endpackage

// ===== src/ssr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_front: window, match and budget bookkeeping
// Accepts input words, compares the window with the find pattern and turns
// each word into at most one burst command for the emitter.
// ----------------------------------------------------------------------------
module ssr_front import ssr_pkg::*; #(
  parameter int MAX_FIND = DEF_MAX_FIND,
  parameter int MAX_REPL = DEF_MAX_REPL
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [BYTE_W-1:0]                     in_byte,
  input  logic                                  has_byte,
  input  logic                                  final_byte,
  input  logic [cap_len(MAX_FIND)*BYTE_W-1:0]   find_pat,
  input  logic [cap_len(MAX_REPL)*BYTE_W-1:0]   repl_pat,
  input  logic [CNT_W-1:0]                      find_len,
  input  logic [CNT_W-1:0]                      repl_len,
  input  logic [TOT_W-1:0]                      out_budget,
  input  cfg_ev_t                               cfg_ev,
  input  logic                                  q_full,
  output logic                                  q_push,
  output cmd_t                                  q_cmd
);

  localparam int WD = cap_len(MAX_FIND);

  logic [BYTE_W-1:0]        win [WD];
  logic [BYTE_W-1:0]        win_p [WD];
  logic [WD*BYTE_W-1:0]     win_pk;
  logic [CNT_W-1:0]         fill;
  logic [CNT_W-1:0]         fill_p;
  logic [CNT_W-1:0]         fill_next;
  logic [CNT_W-1:0]         want;
  logic [CNT_W-1:0]         n;
  logic [TOT_W-1:0]         bw;
  logic [TOT_W-1:0]         room;
  logic [TOT_W-1:0]         bw_step;
  logic [TOT_W-1:0]         room_step;
  logic                     br;
  logic                     br_eff;
  logic                     push;
  logic                     full;
  logic                     hit;
  logic                     proc;
  logic                     shift;
  logic                     acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    br_eff = br || (room == '0);
    push   = !br_eff && has_byte && (fill < find_len);
    for (int i = 0; i < WD; i++) begin
      win_p[i]                 = (push && fill == CNT_W'(i)) ? in_byte : win[i];
      win_pk[i*BYTE_W+:BYTE_W] = win_p[i];
    end
    fill_p = fill + CNT_W'(push);
    full   = (fill_p == find_len);
    hit    = full;
    for (int i = 0; i < WD; i++) begin
      if (CNT_W'(i) < find_len && win_p[i] != find_pat[i*BYTE_W+:BYTE_W]) begin
        hit = 1'b0;
      end
    end
    proc = !br_eff && full;
    if (final_byte) begin
      want = br_eff ? '0 : (hit ? repl_len : fill_p);
    end else begin
      want = proc ? (hit ? repl_len : CNT_W'(1)) : '0;
    end
    // clip the burst at the remaining budget
    n         = (room < TOT_W'(want)) ? room[CNT_W-1:0] : want;
    bw_step   = bw + TOT_W'(n);
    room_step = room - TOT_W'(n);
    shift     = !final_byte && proc && !hit;
    fill_next = proc ? (hit ? '0 : fill_p - CNT_W'(1)) : fill_p;

    q_cmd.data = hit ? (PAT_CAP*BYTE_W)'(repl_pat) : (PAT_CAP*BYTE_W)'(win_pk);
    q_cmd.cnt  = n;
    q_cmd.fin  = final_byte;
    q_cmd.base = bw;
    q_push     = acc && (final_byte || n != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bw   <= '0;
      room <= RESET_BUDGET;
      br   <= 1'b0;
    end else begin
      if (acc) begin
        if (final_byte) begin
          fill <= '0;
          bw   <= '0;
          room <= out_budget;
          br   <= 1'b0;
        end else begin
          fill <= fill_next;
          bw   <= bw_step;
          room <= room_step;
          br   <= br || (room_step == '0);
        end
      end
      if (cfg_ev.clear_fill) begin
        fill <= '0;
      end
      if (cfg_ev.set_budget) begin
        room <= (cfg_ev.budget > bw) ? cfg_ev.budget - bw : '0;
      end
    end
  end

  // window bytes: shift out the oldest byte after a miss
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < WD - 1; i++) begin
        win[i] <= shift ? win_p[i+1] : win_p[i];
      end
      win[WD-1] <= win_p[WD-1];
    end
  end

endmodule

// ===== src/ssr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_queue: command queue between front end and emitter
// Small circular buffer of burst commands with a full flag and a head view.
// ----------------------------------------------------------------------------
module ssr_queue import ssr_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  output logic rd_valid,
  output cmd_t rd_cmd,
  input  logic rd_en
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_QW = $clog2(DEPTH + 1);

  cmd_t              entry [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full     = (count == CNT_QW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_QW'(wr_en) - CNT_QW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// ===== src/ssr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_back: burst emitter
// Unrolls a command into output words, one per cycle unless stalled, into the
// output register; the next command is popped once the last word is loaded.
// ----------------------------------------------------------------------------
module ssr_back import ssr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              item_kind,
  output logic [BYTE_W-1:0] out_char,
  output logic [TOT_W-1:0]  written_total,
  output logic              run_end
);

  logic                      busy;
  logic [PAT_CAP*BYTE_W-1:0] data;
  logic [CNT_W-1:0]          cnt;
  logic                      fin;
  logic [PAT_CAP*BYTE_W-1:0] src_data;
  logic [CNT_W-1:0]          src_cnt;
  logic                      src_fin;
  logic [TOT_W-1:0]          src_tot;
  logic [TOT_W-1:0]          tot;
  logic                      advance;
  logic                      have;
  logic                      is_data;
  logic                      last;

  always_comb begin
    // take the burst in flight, else the queue head
    src_data = busy ? data : q_cmd.data;
    src_cnt  = busy ? cnt : q_cmd.cnt;
    src_fin  = busy ? fin : q_cmd.fin;
    src_tot  = busy ? written_total : q_cmd.base;
    advance  = !out_valid || out_ready;
    have     = busy || q_valid;
    is_data  = (src_cnt != '0);
    last     = is_data ? (src_cnt == CNT_W'(1) && !src_fin) : 1'b1;
    tot      = is_data ? src_tot + TOT_W'(1) : src_tot;
    q_pop    = advance && !busy && q_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else if (advance) begin
      out_valid <= have;
      if (have) begin
        busy <= !last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && have) begin
      item_kind     <= is_data ? KIND_DATA : KIND_END;
      out_char      <= is_data ? src_data[BYTE_W-1:0] : '0;
      written_total <= tot;
      run_end       <= last;
      data          <= src_data >> BYTE_W;
      cnt           <= is_data ? src_cnt - CNT_W'(1) : src_cnt;
      fin           <= src_fin;
    end
  end

endmodule

// ===== src/stream_substring_replace_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_substring_replace_top: streaming find-and-replace over a byte string
// Path: an accepted input word goes through the command queue, then the output
//   register, when the command queue is empty and the emitter is idle.
// Throughput: one input word per cycle while the command queue has room; the
//   emitter writes one output word per cycle while not stalled, so a word that
//   causes k results holds the output side until all k are written (a
//   replacement burst of up to 16 bytes plus the end report is up to 17 words).
// Reset: synchronous, empties window and queue, clears the byte count and the
//   output valid flag; budget and configuration registers return to reset values.
// ----------------------------------------------------------------------------
module stream_substring_replace_top import ssr_pkg::*; #(
  parameter int MAX_FIND    = DEF_MAX_FIND,
  parameter int MAX_REPL    = DEF_MAX_REPL,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input word channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_byte,
  input  logic                  has_byte,
  input  logic                  final_byte,
  // output word channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  item_kind,
  output logic [BYTE_W-1:0]     out_char,
  output logic [TOT_W-1:0]      written_total,
  output logic                  run_end
);

  localparam int FC = cap_len(MAX_FIND);
  localparam int RC = cap_len(MAX_REPL);

  // Configuration registers. Only pattern bytes that can ever be used are
  // stored; lengths are kept already clamped to what the datapath supports.
  logic [FC*BYTE_W-1:0] find_pat;
  logic [RC*BYTE_W-1:0] repl_pat;
  logic [CNT_W-1:0]     find_len;
  logic [CNT_W-1:0]     repl_len;
  logic [TOT_W-1:0]     out_budget;
  logic [CNT_W-1:0]     len_raw;
  logic [CNT_W-1:0]     find_len_w;
  logic [CNT_W-1:0]     repl_len_w;
  cfg_ev_t              cfg_ev;

  // front end to queue, queue to emitter
  logic                 q_full;
  logic                 q_push;
  cmd_t                 q_wr_cmd;
  logic                 q_valid;
  cmd_t                 q_rd_cmd;
  logic                 q_pop;

  always_comb begin
    len_raw = cfg_data[CNT_W-1:0];
    // an empty find pattern acts as one byte; long ones saturate
    if (len_raw == '0) begin
      find_len_w = CNT_W'(1);
    end else if (len_raw > CNT_W'(FC)) begin
      find_len_w = CNT_W'(FC);
    end else begin
      find_len_w = len_raw;
    end
    repl_len_w = (len_raw > CNT_W'(RC)) ? CNT_W'(RC) : len_raw;

    // a new pattern length drops whatever the window holds
    cfg_ev.clear_fill = cfg_write && (cfg_index == REG_FIND_LEN);
    cfg_ev.set_budget = cfg_write && (cfg_index == REG_BUDGET);
    cfg_ev.budget     = cfg_data[TOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      find_pat   <= '0;
      repl_pat   <= '0;
      find_len   <= CNT_W'(1);
      repl_len   <= '0;
      out_budget <= RESET_BUDGET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FIND_LO: begin
          for (int b = 0; b < FC && b < 8; b++) begin
            find_pat[b*BYTE_W+:BYTE_W] <= cfg_data[b*BYTE_W+:BYTE_W];
          end
        end
        REG_FIND_HI: begin
          for (int b = 8; b < FC; b++) begin
            find_pat[b*BYTE_W+:BYTE_W] <= cfg_data[(b-8)*BYTE_W+:BYTE_W];
          end
        end
        REG_FIND_LEN: find_len <= find_len_w;
        REG_REPL_LO: begin
          for (int b = 0; b < RC && b < 8; b++) begin
            repl_pat[b*BYTE_W+:BYTE_W] <= cfg_data[b*BYTE_W+:BYTE_W];
          end
        end
        REG_REPL_HI: begin
          for (int b = 8; b < RC; b++) begin
            repl_pat[b*BYTE_W+:BYTE_W] <= cfg_data[(b-8)*BYTE_W+:BYTE_W];
          end
        end
        REG_REPL_LEN: repl_len <= repl_len_w;
        REG_BUDGET:   out_budget <= cfg_data[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: shift bytes into the window, match, account the budget and
  // hand one burst command per productive word to the queue.
  ssr_front #(
    .MAX_FIND (MAX_FIND),
    .MAX_REPL (MAX_REPL)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .has_byte   (has_byte),
    .final_byte (final_byte),
    .find_pat   (find_pat),
    .repl_pat   (repl_pat),
    .find_len   (find_len),
    .repl_len   (repl_len),
    .out_budget (out_budget),
    .cfg_ev     (cfg_ev),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_wr_cmd)
  );

  // Queue: absorb replacement bursts so input keeps flowing.
  ssr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_cmd   (q_wr_cmd),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_cmd   (q_rd_cmd),
    .rd_en    (q_pop)
  );

  // Emitter: one word per cycle into the output register while not stalled.
  ssr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_rd_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .item_kind     (item_kind),
    .out_char      (out_char),
    .written_total (written_total),
    .run_end       (run_end)
  );

endmodule

// ===== src/ssr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_checker: port-level checks for the substring replace block
// Watches the output channel for stalls, end reports and byte counting.
// ----------------------------------------------------------------------------
module ssr_checker import ssr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              item_kind,
  input logic [BYTE_W-1:0] out_char,
  input logic [TOT_W-1:0]  written_total,
  input logic              run_end
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(out_char)
      && $stable(written_total) && $stable(run_end))
    else $error("output word changed while stalled");

  // an end report closes its run and carries no byte
  a_end_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_END |-> run_end && out_char == '0)
    else $error("end report without run_end or with data");

  // every data word counts itself
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_DATA |-> written_total != '0)
    else $error("data word with zero byte count");

  // inside a run, words follow without a gap and the count steps by one
  a_run_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && item_kind == KIND_DATA && !run_end |=> out_valid
      && ((item_kind == KIND_DATA && written_total == $past(written_total) + 16'd1)
       || (item_kind == KIND_END && written_total == $past(written_total))))
    else $error("broken run of output words");

endmodule

bind stream_substring_replace_top ssr_checker u_ssr_checker (.*);
